// ----- rtl/slec_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slec_pkg
// Shared types, widths and codes for the sequential list engine.
// ----------------------------------------------------------------------------
package slec_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 7;
	// width used for position versus cell index compares
	localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_GET    = 3'd3;
	localparam logic [2:0] OP_LOCATE = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADPOS   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef struct packed {
		logic [2:0]        operation;
		logic [POS_W-1:0]  position;
		logic signed [31:0] item_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [POS_W-1:0]   found_position;
		logic [POS_W-1:0]   entry_count;
	} res_t;

	// control broadcast to every cell of the row
	typedef struct packed {
		logic          ins;
		logic          del;
		logic [CW-1:0] pos_m1;
		logic [CW-1:0] count;
		data_t         key;
	} bcast_t;

endpackage : slec_pkg
`default_nettype wire

// ----- rtl/slec_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slec_cell
// One list entry: shifts from a neighbor, loads, and reports match and read.
// ----------------------------------------------------------------------------
module slec_cell import slec_pkg::*; (
	input  wire logic             clk,
	input  wire logic [IDX_W-1:0] idx,
	input  wire bcast_t           bc,
	input  wire data_t            left,
	input  wire data_t            right,
	output data_t                 word,
	output logic                  match,
	output data_t                 rd
);

	data_t         word_q;
	logic [CW-1:0] idx_c;

	assign idx_c = CW'(idx);

	always_ff @(posedge clk) begin
		if (bc.ins && (idx_c > bc.pos_m1)) begin
			word_q <= left;
		end else if (bc.ins && (idx_c == bc.pos_m1)) begin
			word_q <= bc.key;
		end else if (bc.del && (idx_c >= bc.pos_m1)) begin
			word_q <= right;
		end
	end

	assign word  = word_q;
	assign match = (word_q == bc.key) && (idx_c < bc.count);
	assign rd    = (idx_c == bc.pos_m1) ? word_q : '0;

endmodule : slec_cell
`default_nettype wire

// ----- rtl/slec_row.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slec_row
// Row of list cells with neighbor links, match vector and read-out.
// ----------------------------------------------------------------------------
module slec_row import slec_pkg::*; (
	input  wire logic          clk,
	input  wire bcast_t        bc,
	output logic [DEPTH-1:0]   match,
	output data_t              rd
);

	data_t words [DEPTH];
	data_t rds   [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		data_t left_w;
		data_t right_w;

		if (k == 0) begin : g_first
			assign left_w = bc.key;
		end else begin : g_mid_l
			assign left_w = words[k-1];
		end

		if (k == DEPTH - 1) begin : g_last
			assign right_w = words[k];
		end else begin : g_mid_r
			assign right_w = words[k+1];
		end

		slec_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(k)),
			.bc    (bc),
			.left  (left_w),
			.right (right_w),
			.word  (words[k]),
			.match (match[k]),
			.rd    (rds[k])
		);
	end

	// at most one cell drives a nonzero read word
	always_comb begin
		rd = '0;
		for (int k = 0; k < DEPTH; k++) begin
			rd = rd | rds[k];
		end
	end

endmodule : slec_row
`default_nettype wire

// ----- rtl/sequential_list_engine_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_list_engine_core
// Ordered list of signed words held in a row of cells, with insert, delete,
// get, locate and clear.
//
//   channel | valid     | stall     | payload
//   command | cmd_valid | cmd_stall | cmd (cmd_t)
//   result  | res_valid | res_stall | res (res_t)
//
// One command per cycle while cmd_stall is low; results pass s1 then res_q.
// The cell row shifts, compares and reads all entries in the accept cycle;
// the first-match encode for locate runs in the following stage.
// Reset clears the count and the pipeline valids; entries are not cleared.
// A stalled result holds both stages, and cmd_stall rises once they are full.
// ----------------------------------------------------------------------------
module sequential_list_engine_core import slec_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             out_adv;
	logic [CW:0]      pos_x;
	logic [CW:0]      cnt_x;
	logic             pos_ok_ins;
	logic             pos_ok_rd;
	logic             full;
	logic             ins_go;
	logic             del_go;
	bcast_t           bc;
	logic [DEPTH-1:0] match;
	data_t            rd;
	logic [1:0]       status_c;
	logic             use_rd;

	logic             v_s1;
	logic [2:0]       op_s1;
	logic [1:0]       status_s1;
	data_t            rd_s1;
	logic [DEPTH-1:0] match_s1;
	logic [CNT_W-1:0] cnt_s1;

	logic [DEPTH-1:0] lowest;
	logic [POS_W-1:0] found;
	res_t             res_d;
	res_t             res_q;
	logic             res_valid_q;

	assign out_adv   = !res_valid_q || !res_stall;
	assign cmd_stall = v_s1 && !out_adv;
	assign accept    = cmd_valid && !cmd_stall;

	assign pos_x      = (CW + 1)'(cmd.position);
	assign cnt_x      = (CW + 1)'(cnt_q);
	assign pos_ok_ins = (cmd.position != '0) && (pos_x <= cnt_x + 1'b1);
	assign pos_ok_rd  = (cmd.position != '0) && (pos_x <= cnt_x);
	assign full       = (cnt_x == (CW + 1)'(DEPTH));

	assign ins_go = accept && (cmd.operation == OP_INSERT) && pos_ok_ins && !full;
	assign del_go = accept && (cmd.operation == OP_DELETE) && pos_ok_rd;

	assign bc.ins    = ins_go;
	assign bc.del    = del_go;
	assign bc.pos_m1 = CW'(cmd.position) - 1'b1;
	assign bc.count  = CW'(cnt_q);
	assign bc.key    = data_t'(cmd.item_value);

	slec_row u_row (
		.clk   (clk),
		.bc    (bc),
		.match (match),
		.rd    (rd)
	);

	always_comb begin
		status_c = ST_OK;
		use_rd   = 1'b0;
		unique case (cmd.operation) inside
			OP_INSERT: begin
				if (!pos_ok_ins) begin
					status_c = ST_BADPOS;
				end else if (full) begin
					status_c = ST_FULL;
				end
			end
			OP_DELETE, OP_GET: begin
				if (!pos_ok_rd) begin
					status_c = ST_BADPOS;
				end else begin
					use_rd = 1'b1;
				end
			end
			default: begin
				status_c = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (!cmd_stall) begin
				v_s1 <= cmd_valid;
			end
			if (accept && (cmd.operation == OP_CLEAR)) begin
				cnt_q <= '0;
			end else if (ins_go) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (del_go) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= cmd.operation;
			status_s1 <= status_c;
			rd_s1     <= use_rd ? rd : '0;
			match_s1  <= match;
			if (cmd.operation == OP_CLEAR) begin
				cnt_s1 <= '0;
			end else if (ins_go) begin
				cnt_s1 <= cnt_q + 1'b1;
			end else if (del_go) begin
				cnt_s1 <= cnt_q - 1'b1;
			end else begin
				cnt_s1 <= cnt_q;
			end
		end
	end

	// isolate the lowest matching cell, then encode its 1-based position
	assign lowest = match_s1 & (~match_s1 + 1'b1);

	always_comb begin
		found = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (lowest[k]) begin
				found = found | POS_W'(k + 1);
			end
		end
	end

	always_comb begin
		res_d.status         = status_s1;
		res_d.read_value     = 32'(signed'(rd_s1));
		res_d.found_position = '0;
		res_d.entry_count    = POS_W'(cnt_s1);
		if (op_s1 == OP_LOCATE) begin
			if (match_s1 != '0) begin
				res_d.status         = ST_OK;
				res_d.found_position = found;
			end else begin
				res_d.status = ST_NOTFOUND;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_adv) begin
			res_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && v_s1) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule : sequential_list_engine_core
`default_nettype wire
